// ----- rtl/psq_pkg.sv -----
// psq_pkg: shared constants, codes and types of the playhead loop sequencer.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package psq_pkg;

   // request / response packing
   localparam int REQ_DATA_W = 48;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 18;

   // field widths
   localparam int FRAME_W = 16;
   localparam int RATE_W = 18;
   localparam int SPEED_W = 16;
   localparam int MODE_W = 2;
   localparam int DT_W = 24;
   localparam int SEEK_W = 17;
   localparam int POS_W = 48;
   localparam int POS_FRAC_BITS = 16;
   localparam int DUR_W = FRAME_W + POS_FRAC_BITS;

   // shared multiplier operand widths
   localparam int MUL_A_W = 24;
   localparam int MUL_B_W = 18;
   localparam int MUL_Q_W = MUL_A_W + MUL_B_W;
   localparam int MUL_SPLIT = 21;

   // shared divider
   localparam int DIV_STEP_W = 6;
   localparam int DIV_Q_W = 16;

   localparam logic [SEEK_W-1:0] SEEK_ONE = 17'd65536;
   localparam logic [POS_W-1:0] POS_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [POS_W-1:0] POS_MIN = 48'h8000_0000_0000;

   // opcodes
   localparam logic [REQ_USER_W-1:0] OP_TICK = 2'd0;
   localparam logic [REQ_USER_W-1:0] OP_SEEK = 2'd1;
   localparam logic [REQ_USER_W-1:0] OP_RESTART = 2'd2;

   // loop modes, anything else behaves as one-shot
   localparam logic [MODE_W-1:0] MODE_LOOP = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PINGPONG = 2'd1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_COUNT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_RATE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_REVERSE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOOP_MODE = 3'd4;

   localparam logic [DIV_STEP_W-1:0] DIV_STEPS_MOD = 6'd48;
   localparam logic [DIV_STEP_W-1:0] DIV_STEPS_PHEAD = 6'd16;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL_A,
      S_MUL_LO,
      S_MUL_HI,
      S_MAG,
      S_ADD,
      S_BOUND,
      S_MOD,
      S_FRAME,
      S_PHEAD,
      S_SEEK_A,
      S_SEEK_B,
      S_SEEK_C,
      S_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic [DUR_W-1:0] rem_init;
      logic [POS_W-1:0] dividend;
      logic [DIV_STEP_W-1:0] steps;
      logic [DUR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic done;
      logic [DIV_Q_W-1:0] quotient;
      logic [DUR_W-1:0] remainder;
   } div_rsp_type;

endpackage

// ----- rtl/psq_mul.sv -----
// psq_mul: shared unsigned multiplier with a registered product.
// Depends on psq_pkg for operand widths.
`timescale 1ns / 1ps

module psq_mul (
   input  logic                          clock,
   input  logic [psq_pkg::MUL_A_W-1:0]   mul_a,
   input  logic [psq_pkg::MUL_B_W-1:0]   mul_b,
   output logic [psq_pkg::MUL_Q_W-1:0]   mul_q
);

   logic [psq_pkg::MUL_Q_W-1:0] prod_ff;
   logic [psq_pkg::MUL_Q_W-1:0] prod_in;

   assign prod_in = {{psq_pkg::MUL_B_W{1'b0}}, mul_a} * {{psq_pkg::MUL_A_W{1'b0}}, mul_b};
   assign mul_q = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ----- rtl/psq_div.sv -----
// psq_div: restoring divider, one quotient bit per cycle, shared by the
// loop modulo and the playhead division. Depends on psq_pkg.
`timescale 1ns / 1ps

module psq_div (
   input  logic                  clock,
   input  logic                  reset,
   input  psq_pkg::div_req_type  div_req,
   output psq_pkg::div_rsp_type  div_rsp
);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [psq_pkg::DIV_STEP_W-1:0] cnt_ff, cnt_in;
   logic [psq_pkg::DUR_W-1:0]      rem_ff, rem_in;
   logic [psq_pkg::POS_W-1:0]      dvd_ff, dvd_in;
   logic [psq_pkg::DUR_W-1:0]      dsr_ff, dsr_in;
   logic [psq_pkg::DIV_Q_W-1:0]    quot_ff, quot_in;
   logic [psq_pkg::DUR_W:0]        trial;
   logic                           fits;

   // partial remainder with the next dividend bit brought down
   assign trial = {rem_ff, dvd_ff[psq_pkg::POS_W-1]};
   assign fits = trial >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      dsr_in = dsr_ff;
      quot_in = quot_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in = div_req.steps;
         rem_in = div_req.rem_init;
         dvd_in = div_req.dividend;
         dsr_in = div_req.divisor;
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in = fits ? trial[psq_pkg::DUR_W-1:0] - dsr_ff : trial[psq_pkg::DUR_W-1:0];
         dvd_in = {dvd_ff[psq_pkg::POS_W-2:0], 1'b0};
         quot_in = {quot_ff[psq_pkg::DIV_Q_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      quot_ff <= quot_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quotient = quot_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

// ----- rtl/playhead_loop_sequencer.sv -----
// playhead_loop_sequencer: frame sequence playhead with loop, ping-pong and one-shot ends.
// Restart and idle tick respond directly; seek uses two passes through the shared multiplier;
// tick uses three passes through it and the restoring divider (48 steps for the wrap modulo,
// only when the loop wraps, and 16 for the playhead).
// One request at a time; the next is taken the cycle after the response is registered.
// Synchronous active-high reset: registers to their defaults, position 0, playing, forward.
`timescale 1ns / 1ps

module playhead_loop_sequencer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // dt_seconds [23:0], seek_position [40:24], zero pad [47:41]
   input  logic [psq_pkg::REQ_DATA_W-1:0]    req_tdata,
   // opcode [1:0]
   input  logic [psq_pkg::REQ_USER_W-1:0]    req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // frame_index [15:0], playhead [32:16], is_playing [33], forward_dir [34], zero pad [39:35]
   output logic [psq_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [psq_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [psq_pkg::CSR_DATA_W-1:0]    csr_data
);

   psq_pkg::state_type state_ff, state_in;

   logic [psq_pkg::FRAME_W-1:0] frame_count_ff;
   logic [psq_pkg::RATE_W-1:0]  frame_rate_ff;
   logic [psq_pkg::SPEED_W-1:0] speed_ff;
   logic                        reverse_ff;
   logic [psq_pkg::MODE_W-1:0]  loop_mode_ff;

   logic [psq_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic                        fwd_ff, fwd_in;
   logic                        play_ff, play_in;
   logic [psq_pkg::FRAME_W-1:0] frame_ff, frame_in;
   logic [psq_pkg::SEEK_W-1:0]  phead_ff, phead_in;

   logic [psq_pkg::DT_W-1:0]    dt_ff, dt_in;
   logic [psq_pkg::SEEK_W-1:0]  seek_ff, seek_in;
   logic [psq_pkg::MUL_Q_W-psq_pkg::MUL_SPLIT-1:0] ahi_ff, ahi_in;
   logic [psq_pkg::MUL_SPLIT+psq_pkg::SPEED_W-1:0] lo_ff, lo_in;
   logic [psq_pkg::MUL_Q_W-1:0] mag_ff, mag_in;
   logic                        mod_neg_ff, mod_neg_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [psq_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [psq_pkg::MUL_A_W-1:0] mul_a;
   logic [psq_pkg::MUL_B_W-1:0] mul_b;
   logic [psq_pkg::MUL_Q_W-1:0] mul_q;
   psq_pkg::div_req_type        div_req;
   psq_pkg::div_rsp_type        div_rsp;

   logic [psq_pkg::DUR_W-1:0]   dur;
   logic [psq_pkg::FRAME_W-1:0] n_m1;
   logic [psq_pkg::SPEED_W-1:0] smag;
   logic                        neg_dir;
   logic [psq_pkg::SEEK_W-1:0]  seek_clamp;
   logic [57:0]                 mag_wide;
   logic [psq_pkg::POS_W:0]     sum;
   logic                        pos_ge_dur;
   logic                        pos_le_zero;
   logic [psq_pkg::DUR_W-1:0]   whole_frames;

   psq_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_q (mul_q)
   );

   psq_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign csr_ready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   assign dur = {frame_count_ff, {psq_pkg::POS_FRAC_BITS{1'b0}}};
   assign n_m1 = frame_count_ff - 1'b1;
   assign smag = speed_ff[psq_pkg::SPEED_W-1] ? (16'd0 - speed_ff) : speed_ff;
   assign neg_dir = speed_ff[psq_pkg::SPEED_W-1] ^ reverse_ff
                    ^ ((loop_mode_ff == psq_pkg::MODE_PINGPONG) && !fwd_ff);
   assign seek_clamp = (req_tdata[40:24] > psq_pkg::SEEK_ONE) ? psq_pkg::SEEK_ONE
                                                              : req_tdata[40:24];
   // dt*rate*|speed| from the two partial products, 32 fraction bits
   assign mag_wide = {mul_q[36:0], 21'd0} + {21'd0, lo_ff};
   assign sum = pos_ff[psq_pkg::POS_W-1]
                ? {1'b1, pos_ff} + (neg_dir ? -{7'd0, mag_ff} : {7'd0, mag_ff})
                : {1'b0, pos_ff} + (neg_dir ? -{7'd0, mag_ff} : {7'd0, mag_ff});
   assign pos_ge_dur = !pos_ff[psq_pkg::POS_W-1] && (pos_ff >= {16'd0, dur});
   assign pos_le_zero = pos_ff[psq_pkg::POS_W-1] || (pos_ff == '0);
   assign whole_frames = pos_ff[psq_pkg::POS_W-1:psq_pkg::POS_FRAC_BITS];

   always_comb begin
      state_in = state_ff;
      pos_in = pos_ff;
      fwd_in = fwd_ff;
      play_in = play_ff;
      frame_in = frame_ff;
      phead_in = phead_ff;
      dt_in = dt_ff;
      seek_in = seek_ff;
      ahi_in = ahi_ff;
      lo_in = lo_ff;
      mag_in = mag_ff;
      mod_neg_in = mod_neg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      mul_a = '0;
      mul_b = '0;
      div_req = '0;
      req_tready = 1'b0;
      case (state_ff)
         psq_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               dt_in = req_tdata[23:0];
               seek_in = seek_clamp;
               case (req_tuser)
                  psq_pkg::OP_TICK: begin
                     if (play_ff && (frame_count_ff != '0) && (frame_rate_ff != '0)) begin
                        state_in = psq_pkg::S_MUL_A;
                     end else begin
                        state_in = psq_pkg::S_OUT;
                     end
                  end
                  psq_pkg::OP_SEEK: begin
                     state_in = psq_pkg::S_SEEK_A;
                  end
                  psq_pkg::OP_RESTART: begin
                     pos_in = '0;
                     frame_in = '0;
                     phead_in = '0;
                     fwd_in = 1'b1;
                     play_in = 1'b1;
                     state_in = psq_pkg::S_OUT;
                  end
                  default: begin
                     state_in = psq_pkg::S_OUT;
                  end
               endcase
            end
         end
         psq_pkg::S_MUL_A: begin
            mul_a = dt_ff;
            mul_b = frame_rate_ff;
            state_in = psq_pkg::S_MUL_LO;
         end
         psq_pkg::S_MUL_LO: begin
            ahi_in = mul_q[psq_pkg::MUL_Q_W-1:psq_pkg::MUL_SPLIT];
            mul_a = {3'd0, mul_q[psq_pkg::MUL_SPLIT-1:0]};
            mul_b = {2'd0, smag};
            state_in = psq_pkg::S_MUL_HI;
         end
         psq_pkg::S_MUL_HI: begin
            lo_in = mul_q[36:0];
            mul_a = {3'd0, ahi_ff};
            mul_b = {2'd0, smag};
            state_in = psq_pkg::S_MAG;
         end
         psq_pkg::S_MAG: begin
            mag_in = mag_wide[57:16];
            state_in = psq_pkg::S_ADD;
         end
         psq_pkg::S_ADD: begin
            if (sum[psq_pkg::POS_W] != sum[psq_pkg::POS_W-1]) begin
               pos_in = sum[psq_pkg::POS_W] ? psq_pkg::POS_MIN : psq_pkg::POS_MAX;
            end else begin
               pos_in = sum[psq_pkg::POS_W-1:0];
            end
            state_in = psq_pkg::S_BOUND;
         end
         psq_pkg::S_BOUND: begin
            state_in = psq_pkg::S_FRAME;
            div_req.divisor = dur;
            div_req.rem_init = '0;
            div_req.steps = psq_pkg::DIV_STEPS_MOD;
            if (pos_ge_dur) begin
               if (loop_mode_ff == psq_pkg::MODE_LOOP) begin
                  div_req.start = 1'b1;
                  div_req.dividend = pos_ff;
                  mod_neg_in = 1'b0;
                  state_in = psq_pkg::S_MOD;
               end else if (loop_mode_ff == psq_pkg::MODE_PINGPONG) begin
                  pos_in = {15'd0, dur, 1'b0} - pos_ff;
                  fwd_in = 1'b0;
               end else begin
                  pos_in = {16'd0, dur};
                  play_in = 1'b0;
               end
            end else if (pos_ff[psq_pkg::POS_W-1]) begin
               if (loop_mode_ff == psq_pkg::MODE_LOOP) begin
                  div_req.start = 1'b1;
                  div_req.dividend = 48'd0 - pos_ff;
                  mod_neg_in = 1'b1;
                  state_in = psq_pkg::S_MOD;
               end else if (loop_mode_ff == psq_pkg::MODE_PINGPONG) begin
                  pos_in = (pos_ff == psq_pkg::POS_MIN) ? psq_pkg::POS_MAX : 48'd0 - pos_ff;
                  fwd_in = 1'b1;
               end else begin
                  pos_in = '0;
                  play_in = 1'b0;
               end
            end
         end
         psq_pkg::S_MOD: begin
            if (div_rsp.done) begin
               if (!mod_neg_ff) begin
                  pos_in = {16'd0, div_rsp.remainder};
               end else if (div_rsp.remainder == '0) begin
                  pos_in = '0;
               end else begin
                  pos_in = {16'd0, dur - div_rsp.remainder};
               end
               state_in = psq_pkg::S_FRAME;
            end
         end
         psq_pkg::S_FRAME: begin
            if (pos_le_zero) begin
               frame_in = '0;
               phead_in = '0;
               state_in = psq_pkg::S_OUT;
            end else begin
               frame_in = (whole_frames >= {16'd0, frame_count_ff}) ? n_m1
                                                                     : whole_frames[15:0];
               if (pos_ge_dur) begin
                  phead_in = psq_pkg::SEEK_ONE;
                  state_in = psq_pkg::S_OUT;
               end else begin
                  // position is below the duration, so it seeds the remainder directly
                  div_req.start = 1'b1;
                  div_req.rem_init = pos_ff[psq_pkg::DUR_W-1:0];
                  div_req.dividend = '0;
                  div_req.steps = psq_pkg::DIV_STEPS_PHEAD;
                  div_req.divisor = dur;
                  state_in = psq_pkg::S_PHEAD;
               end
            end
         end
         psq_pkg::S_PHEAD: begin
            if (div_rsp.done) begin
               phead_in = {1'b0, div_rsp.quotient};
               state_in = psq_pkg::S_OUT;
            end
         end
         psq_pkg::S_SEEK_A: begin
            mul_a = {7'd0, seek_ff};
            mul_b = {2'd0, frame_count_ff};
            state_in = psq_pkg::S_SEEK_B;
         end
         psq_pkg::S_SEEK_B: begin
            pos_in = {6'd0, mul_q};
            mul_a = {7'd0, seek_ff};
            mul_b = {2'd0, n_m1};
            state_in = psq_pkg::S_SEEK_C;
         end
         psq_pkg::S_SEEK_C: begin
            frame_in = (frame_count_ff == '0) ? '0 : mul_q[31:16];
            phead_in = seek_ff;
            state_in = psq_pkg::S_OUT;
         end
         psq_pkg::S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {5'd0, fwd_ff, play_ff, phead_ff, frame_ff};
               state_in = psq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = psq_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= psq_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         fwd_ff <= 1'b1;
         play_ff <= 1'b1;
         frame_ff <= '0;
         phead_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         fwd_ff <= fwd_in;
         play_ff <= play_in;
         frame_ff <= frame_in;
         phead_ff <= phead_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dt_ff <= dt_in;
      seek_ff <= seek_in;
      ahi_ff <= ahi_in;
      lo_ff <= lo_in;
      mag_ff <= mag_in;
      mod_neg_ff <= mod_neg_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= '0;
         frame_rate_ff <= 18'd7680;
         speed_ff <= 16'd256;
         reverse_ff <= 1'b0;
         loop_mode_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            psq_pkg::CSR_FRAME_COUNT: frame_count_ff <= csr_data[psq_pkg::FRAME_W-1:0];
            psq_pkg::CSR_FRAME_RATE:  frame_rate_ff <= csr_data;
            psq_pkg::CSR_SPEED:       speed_ff <= csr_data[psq_pkg::SPEED_W-1:0];
            psq_pkg::CSR_REVERSE:     reverse_ff <= csr_data[0];
            psq_pkg::CSR_LOOP_MODE:   loop_mode_ff <= csr_data[psq_pkg::MODE_W-1:0];
            default: begin
            end
         endcase
      end
   end

endmodule

// ----- rtl/psq_checker.sv -----
// psq_assertions: port-level assertions for the playhead loop sequencer, bound to the top level.
// Depends on psq_pkg and playhead_loop_sequencer.
`timescale 1ns / 1ps

module psq_assertions (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [psq_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // no response comes out of reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // the block does not accept a request in the cycle after it accepted one
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken on back-to-back cycles");

   // playhead never leaves 0..1.0
   a_phead_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[32:16] <= psq_pkg::SEEK_ONE)
      else $error("playhead out of range");

   // padding above the status fields stays zero
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[39:35] == 5'd0)
      else $error("response padding not zero");

endmodule

bind playhead_loop_sequencer psq_assertions u_psq_assertions (.*);
